>>> rtl/lev_pkg.sv
`default_nettype none

package lev_pkg;

   // Command codes carried on req_tuser.
   localparam logic [1:0] CMD_REF    = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;

   localparam int CMD_W       = 2;
   localparam int SYM_W       = 8;
   localparam int DIST_W      = 9;
   localparam int RSP_TDATA_W = 16;

   // Enables from the sequencer to the row and reference memories.
   typedef struct packed {
      logic ref_we;
      logic row_we;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

>>> rtl/levenshtein_distance_engine_unit.sv
`default_nettype none

// Levenshtein edit distance engine. Send the reference string first, one byte per
// transfer with command 0, then the query string with command 1, then command 2 to
// receive the distance and a sticky error status and to clear the block. A reference
// byte and a report are taken without a walk; a query byte makes one shared edit-cost
// cell walk the stored cost row one entry per cycle through a memory with one read
// and one write port, and then drain the last cell. A query byte against an empty
// reference, like any dropped byte, is taken without a walk. The input is not ready
// while that walk runs, nor while a finished result waits to be taken.
// Bytes beyond MAX_LEN, or reference bytes after the first query byte, are dropped
// and raise the error status until the next report.
module levenshtein_distance_engine_unit #(
   parameter int MAX_LEN = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] symbol
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [8:0] distance, [15:9] zero
   output logic [0:0]       rsp_tuser    // [0] status
);
   import lev_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [LW-1:0]     ref_len_ff, ref_len_in;
   logic [LW-1:0]     qcount_ff, qcount_in;
   logic              err_ff, err_in;
   logic [LW-1:0]     row0_ff, row0_in;
   logic [LW-1:0]     dist_ff, dist_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [LW-1:0]     left_ff, left_in;
   logic [LW-1:0]     diag_ff, diag_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [AW-1:0]     wr_idx_ff, wr_idx_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_stat_ff, rsp_stat_in;

   logic              accept;
   logic              do_ref, do_query, do_report, drop;
   logic              last_issue;
   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     row_wr_addr;
   logic [LW-1:0]     row_wr_data;
   logic [SYM_W-1:0]  ref_rd_data;
   logic [LW-1:0]     row_rd_data;
   logic [LW-1:0]     cell_cost;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      do_ref    = 1'b0;
      do_query  = 1'b0;
      do_report = 1'b0;
      drop      = 1'b0;
      if (accept) begin
         unique case (req_tuser)
            CMD_REF: begin
               if (qcount_ff == '0 && ref_len_ff < LW'(MAX_LEN)) begin
                  do_ref = 1'b1;
               end else begin
                  drop = 1'b1;
               end
            end
            CMD_QUERY: begin
               if (qcount_ff < LW'(MAX_LEN)) begin
                  do_query = 1'b1;
               end else begin
                  drop = 1'b1;
               end
            end
            CMD_REPORT: do_report = 1'b1;
            default: ;
         endcase
      end
   end

   assign last_issue = ({{(LW-AW){1'b0}}, rd_idx_ff} == ref_len_ff - LW'(1));

   always_comb begin
      state_in   = state_ff;
      ref_len_in = ref_len_ff;
      qcount_in  = qcount_ff;
      err_in     = err_ff || drop;
      row0_in    = row0_ff;
      dist_in    = dist_ff;
      sym_in     = sym_ff;
      left_in    = left_ff;
      diag_in    = diag_ff;
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = rd_idx_ff;
      pend_in    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (do_ref) begin
               ref_len_in = ref_len_ff + LW'(1);
               dist_in    = ref_len_ff + LW'(1);
            end
            if (do_query) begin
               qcount_in = qcount_ff + LW'(1);
               row0_in   = qcount_ff + LW'(1);
               left_in   = qcount_ff + LW'(1);
               diag_in   = row0_ff;
               sym_in    = req_tdata;
               rd_idx_in = '0;
               if (ref_len_ff == '0) begin
                  dist_in = qcount_ff + LW'(1);
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            pend_in   = 1'b1;
            rd_idx_in = rd_idx_ff + AW'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // The cell computed from the data read in the cycle before.
      if (pend_ff) begin
         left_in = cell_cost;
         diag_in = row_rd_data;
         if (state_ff == ST_DRAIN) begin
            dist_in = cell_cost;
         end
      end

      if (do_report) begin
         ref_len_in = '0;
         qcount_in  = '0;
         err_in     = 1'b0;
         row0_in    = '0;
         dist_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (do_report) begin
         rsp_valid_in = 1'b1;
         rsp_dist_in  = DIST_W'(dist_ff);
         rsp_stat_in  = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_len_ff   <= '0;
         qcount_ff    <= '0;
         err_ff       <= 1'b0;
         row0_ff      <= '0;
         dist_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_len_ff   <= ref_len_in;
         qcount_ff    <= qcount_in;
         err_ff       <= err_in;
         row0_ff      <= row0_in;
         dist_ff      <= dist_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      mem_ctl.ref_we = do_ref;
      mem_ctl.row_we = do_ref || pend_ff;
      mem_ctl.rd_en  = (state_ff == ST_WALK);
      if (pend_ff) begin
         row_wr_addr = wr_idx_ff;
         row_wr_data = cell_cost;
      end else begin
         row_wr_addr = ref_len_ff[AW-1:0];
         row_wr_data = ref_len_ff + LW'(1);
      end
   end

   lev_mem #(
      .DEPTH (MAX_LEN),
      .AW    (AW),
      .CW    (LW)
   ) u_mem (
      .clock       (clock),
      .ctl         (mem_ctl),
      .ref_wr_addr (ref_len_ff[AW-1:0]),
      .ref_wr_data (req_tdata),
      .row_wr_addr (row_wr_addr),
      .row_wr_data (row_wr_data),
      .rd_addr     (rd_idx_ff),
      .ref_rd_data (ref_rd_data),
      .row_rd_data (row_rd_data)
   );

   lev_cell #(
      .CW (LW)
   ) u_cell (
      .up      (row_rd_data),
      .left    (left_ff),
      .diag    (diag_ff),
      .ref_sym (ref_rd_data),
      .qry_sym (sym_ff),
      .cost    (cell_cost)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DIST_W){1'b0}}, rsp_dist_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule

`default_nettype wire

>>> rtl/lev_cell.sv
`default_nettype none

module lev_cell #(
   parameter int CW = 9
) (
   input  wire logic [CW-1:0]          up,
   input  wire logic [CW-1:0]          left,
   input  wire logic [CW-1:0]          diag,
   input  wire logic [lev_pkg::SYM_W-1:0] ref_sym,
   input  wire logic [lev_pkg::SYM_W-1:0] qry_sym,
   output logic      [CW-1:0]          cost
);
   import lev_pkg::*;

   logic [CW-1:0] min_ul;
   logic [CW-1:0] min_all;
   logic [CW:0]   bumped;

   always_comb begin
      min_ul  = (up < left) ? up : left;
      min_all = (min_ul < diag) ? min_ul : diag;
      bumped  = {1'b0, min_all} + (CW+1)'(1);
      // A matching byte carries the diagonal cost over unchanged.
      if (ref_sym == qry_sym) begin
         cost = diag;
      end else begin
         cost = bumped[CW-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/lev_mem.sv
`default_nettype none

module lev_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int CW    = 9
) (
   input  wire logic                       clock,
   input  wire lev_pkg::mem_ctl_type       ctl,
   input  wire logic [AW-1:0]              ref_wr_addr,
   input  wire logic [lev_pkg::SYM_W-1:0]  ref_wr_data,
   input  wire logic [AW-1:0]              row_wr_addr,
   input  wire logic [CW-1:0]              row_wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [lev_pkg::SYM_W-1:0]  ref_rd_data,
   output logic      [CW-1:0]              row_rd_data
);
   import lev_pkg::*;

   // Entry k of the row memory holds cost row entry k+1; entry zero lives in a register.
   logic [SYM_W-1:0] ref_mem [DEPTH];
   logic [CW-1:0]    row_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.ref_we) begin
         ref_mem[ref_wr_addr] <= ref_wr_data;
      end
      if (ctl.rd_en) begin
         ref_rd_data <= ref_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.row_we) begin
         row_mem[row_wr_addr] <= row_wr_data;
      end
      if (ctl.rd_en) begin
         row_rd_data <= row_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/lev_chk.sv
`default_nettype none

module lev_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);
   import lev_pkg::*;

   // Out of reset the block is idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // A report transfer produces a result in the next cycle.
   a_report_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_REPORT) |=> rsp_tvalid)
      else $error("report transfer gave no result");

   // Appending a reference byte never stalls the input.
   a_ref_no_stall: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_REF && !rsp_tvalid) |=> req_tready)
      else $error("input stalled after a reference byte");

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

endmodule

bind levenshtein_distance_engine_unit lev_chk u_lev_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
